[src/blr_pkg.sv]
// ============================================================================
// Bilinear lattice resampler package
// Shared types, field widths and codes for the resampler modules.
// ============================================================================
`default_nettype none

package blr_pkg;

    // Field and register widths.
    localparam int SIZE_W   = 7;    // size registers
    localparam int IDX_W    = 6;    // lattice indexes
    localparam int DATA_W   = 32;   // sample ports, Q16.16
    localparam int FRAC_W   = 16;   // mapped position fraction
    localparam int WGT_W    = FRAC_W + 1;
    localparam int NUM_W    = 2 * IDX_W;          // idx * (old - 1)
    localparam int DVD_W    = NUM_W + FRAC_W;     // dividend of the mapping
    localparam int QUO_W    = IDX_W + FRAC_W;     // integer part and fraction
    localparam int DIV_CYC  = 4;                  // groups of quotient bits per mapping
    localparam int DIV_STEP = DVD_W / DIV_CYC;    // quotient bits per cycle while the mapping steps
    localparam int CFG_IDX_W = 3;

    // Weight of one, 1.0 in 1.16 format.
    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1 << FRAC_W);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_TIME  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OLD_SPACE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_TIME  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEW_SPACE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOUNDARY  = 3'd4;

    // Item operations.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Space boundary modes.
    localparam logic BND_PERIODIC = 1'b0;
    localparam logic BND_OPEN     = 1'b1;

    // Input word.
    typedef struct packed {
        logic                     op;
        logic [IDX_W-1:0]         old_t;
        logic [IDX_W-1:0]         old_x;
        logic signed [DATA_W-1:0] re_in;
        logic signed [DATA_W-1:0] im_in;
        logic [IDX_W-1:0]         new_t;
        logic [IDX_W-1:0]         new_x;
    } t_in_item;

    // Result word.
    typedef struct packed {
        logic signed [DATA_W-1:0] re_out;
        logic signed [DATA_W-1:0] im_out;
        logic [IDX_W-1:0]         point_t;
        logic [IDX_W-1:0]         point_x;
    } t_out_item;

    // Control that travels with each neighbour into the lanes.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_lane_ctl;

    // Clamp a size register to 2..hi.
    function automatic logic [SIZE_W-1:0] f_clamp_size(input logic [SIZE_W-1:0] v,
                                                       input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] r;
        if (v < SIZE_W'(2)) begin
            r = SIZE_W'(2);
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/bilinear_lattice_resampler_top.sv]
// ============================================================================
// Bilinear lattice resampler
// Stores a time-by-space lattice of complex samples and returns bilinear
// interpolations of it at the points of a lattice of another size.
// ============================================================================
// Usage:
//   A word is taken at a clock edge where start is high and busy is low.
//   A load word writes one sample and gives no result. A query word gives
//   one result word, shown on o_result for one cycle with o_strobe high.
//   The receiver cannot hold results off.
//   Every word passes through two stages: the axis mapping (a restoring
//   divider, seven quotient bits a cycle, holding its last group while
//   the fetch stage is busy) and the neighbour fetch (four reads of the
//   single-port sample memory for a query, one write for a load). A new
//   word can be taken while the previous one is fetched. Reset clears
//   the configuration to its defaults and empties the pipeline; the
//   sample memory holds unknown data until it is loaded. Configuration is
//   written through i_cfg_we / i_cfg_idx / i_cfg_wdata, one register per
//   cycle, only while no word is in flight: a rule the user must keep.
// ============================================================================
`default_nettype none

module bilinear_lattice_resampler_top
    import blr_pkg::*;
#(
    parameter int MAX_TIME     = 64,
    parameter int MAX_SPACE    = 64,
    parameter int SAMPLE_WIDTH = 32
)
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire t_in_item             i_item,
    output logic                      o_strobe,
    output t_out_item                 o_result,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [SIZE_W-1:0]    i_cfg_wdata
);

    localparam int DEPTH  = MAX_TIME * MAX_SPACE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int MEM_W  = 2 * SAMPLE_WIDTH;
    localparam int T_LIM  = (MAX_TIME > 64) ? 64 : MAX_TIME;
    localparam int X_LIM  = (MAX_SPACE > 64) ? 64 : MAX_SPACE;

    // Configuration registers.
    logic [SIZE_W-1:0] r_old_time, r_old_space, r_new_time, r_new_space;
    logic              r_boundary;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_old_time  <= SIZE_W'(2);
            r_old_space <= SIZE_W'(2);
            r_new_time  <= SIZE_W'(2);
            r_new_space <= SIZE_W'(2);
            r_boundary  <= BND_PERIODIC;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OLD_TIME:  r_old_time  <= i_cfg_wdata;
                CFG_OLD_SPACE: r_old_space <= i_cfg_wdata;
                CFG_NEW_TIME:  r_new_time  <= i_cfg_wdata;
                CFG_NEW_SPACE: r_new_space <= i_cfg_wdata;
                CFG_BOUNDARY:  r_boundary  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Effective lattice sizes.
    logic [SIZE_W-1:0] w_ot, w_ox, w_nt, w_nx;

    assign w_ot = f_clamp_size(r_old_time,  SIZE_W'(T_LIM));
    assign w_ox = f_clamp_size(r_old_space, SIZE_W'(X_LIM));
    assign w_nt = f_clamp_size(r_new_time,  SIZE_W'(64));
    assign w_nx = f_clamp_size(r_new_space, SIZE_W'(64));

    // Mapping stage control.
    logic       r_d_valid;
    logic [1:0] r_d_cnt;
    t_in_item   r_d_item;
    logic       w_accept, w_take, w_r_free;

    // Fetch stage control.
    logic             r_r_valid;
    logic [1:0]       r_r_cnt;
    t_in_item         r_r_item;
    logic [IDX_W-1:0] r_r_ti, r_r_xi;
    logic [FRAC_W-1:0] r_r_tf, r_r_xf;

    assign w_r_free = !r_r_valid || (r_r_cnt == 2'd3);
    assign w_take   = r_d_valid && (r_d_cnt == 2'd3) && w_r_free;
    assign busy     = r_d_valid && !w_take;
    assign w_accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_valid <= 1'b0;
            r_d_cnt   <= '0;
        end else if (w_accept) begin
            r_d_valid <= 1'b1;
            r_d_cnt   <= '0;
        end else if (w_take) begin
            r_d_valid <= 1'b0;
        end else if (r_d_valid && r_d_cnt != 2'd3) begin
            r_d_cnt <= r_d_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_d_item <= i_item;
        end
    end

    // One mapping unit for each axis.
    logic              w_step;
    logic [IDX_W-1:0]  w_ti, w_xi;
    logic [FRAC_W-1:0] w_tf, w_xf;

    assign w_step = r_d_valid && (r_d_cnt != 2'd3);

    blr_axis_map u_map_t (
        .i_clk  (i_clk),
        .i_load (w_accept),
        .i_step (w_step),
        .i_idx  (i_item.new_t),
        .i_nold (w_ot),
        .i_nnew (w_nt),
        .o_ip   (w_ti),
        .o_frac (w_tf)
    );

    blr_axis_map u_map_x (
        .i_clk  (i_clk),
        .i_load (w_accept),
        .i_step (w_step),
        .i_idx  (i_item.new_x),
        .i_nold (w_ox),
        .i_nnew (w_nx),
        .o_ip   (w_xi),
        .o_frac (w_xf)
    );

    // Fetch stage: one slot per word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid <= 1'b0;
            r_r_cnt   <= '0;
        end else if (w_take) begin
            r_r_valid <= 1'b1;
            r_r_cnt   <= '0;
        end else if (r_r_valid) begin
            r_r_cnt <= r_r_cnt + 2'd1;
            if (r_r_cnt == 2'd3) begin
                r_r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_r_item <= r_d_item;
            r_r_ti   <= w_ti;
            r_r_xi   <= w_xi;
            r_r_tf   <= w_tf;
            r_r_xf   <= w_xf;
        end
    end

    // Neighbour selection: the time neighbour is missing at the last row,
    // the space neighbour wraps or is missing at the last column.
    logic [IDX_W-1:0]  w_ot_m1, w_ox_m1, w_t_next, w_x_next, w_t_sel, w_x_sel;
    logic [ADDR_W-1:0] w_rd_addr, w_wr_addr, w_addr;
    logic              w_rd_en, w_wr_en;

    assign w_ot_m1  = IDX_W'(w_ot - SIZE_W'(1));
    assign w_ox_m1  = IDX_W'(w_ox - SIZE_W'(1));
    assign w_t_next = (r_r_ti < w_ot_m1) ? r_r_ti + IDX_W'(1) : r_r_ti;

    always_comb begin
        if (r_r_xi < w_ox_m1) begin
            w_x_next = r_r_xi + IDX_W'(1);
        end else if (r_boundary == BND_PERIODIC) begin
            w_x_next = '0;
        end else begin
            w_x_next = r_r_xi;
        end
    end

    assign w_t_sel   = r_r_cnt[1] ? w_t_next : r_r_ti;
    assign w_x_sel   = r_r_cnt[0] ? w_x_next : r_r_xi;
    assign w_rd_addr = ADDR_W'(w_x_sel) * ADDR_W'(MAX_TIME) + ADDR_W'(w_t_sel);
    assign w_wr_addr = ADDR_W'(r_r_item.old_x) * ADDR_W'(MAX_TIME)
                     + ADDR_W'(r_r_item.old_t);

    assign w_rd_en = r_r_valid && (r_r_item.op == OP_QUERY);
    assign w_wr_en = r_r_valid && (r_r_item.op == OP_LOAD) && (r_r_cnt == 2'd0)
                  && (32'(r_r_item.old_t) < MAX_TIME)
                  && (32'(r_r_item.old_x) < MAX_SPACE);
    assign w_addr  = w_wr_en ? w_wr_addr : w_rd_addr;

    // Sample memory: imaginary part above the real part.
    logic [MEM_W-1:0] r_mem [DEPTH];
    logic [MEM_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_addr] <= {r_r_item.im_in[SAMPLE_WIDTH-1:0],
                              r_r_item.re_in[SAMPLE_WIDTH-1:0]};
        end
        r_rd_data <= r_mem[w_addr];
    end

    // Weights and control that travel with each read.
    t_lane_ctl        r_rd_ctl;
    logic [WGT_W-1:0] r_rd_wt, r_rd_wx;
    logic [IDX_W-1:0] r_rd_pt, r_rd_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ctl <= '0;
        end else begin
            r_rd_ctl.vld   <= w_rd_en;
            r_rd_ctl.first <= (r_r_cnt == 2'd0);
            r_rd_ctl.last  <= (r_r_cnt == 2'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_wt <= r_r_cnt[1] ? {1'b0, r_r_tf} : WGT_ONE - {1'b0, r_r_tf};
        r_rd_wx <= r_r_cnt[0] ? {1'b0, r_r_xf} : WGT_ONE - {1'b0, r_r_xf};
        r_rd_pt <= r_r_item.new_t;
        r_rd_px <= r_r_item.new_x;
    end

    // Sign-extend the stored parts and offset them to unsigned.
    logic signed [DATA_W-1:0] w_re_s, w_im_s;
    logic [DATA_W-1:0]        w_re_u, w_im_u;

    assign w_re_s = DATA_W'($signed(r_rd_data[SAMPLE_WIDTH-1:0]));
    assign w_im_s = DATA_W'($signed(r_rd_data[MEM_W-1:SAMPLE_WIDTH]));
    assign w_re_u = {~w_re_s[DATA_W-1], w_re_s[DATA_W-2:0]};
    assign w_im_u = {~w_im_s[DATA_W-1], w_im_s[DATA_W-2:0]};

    // Real and imaginary lanes side by side.
    logic              w_re_done, w_im_done;
    logic [DATA_W-1:0] w_re_top, w_im_top;

    blr_lane u_lane_re (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_u     (w_re_u),
        .i_wt    (r_rd_wt),
        .i_wx    (r_rd_wx),
        .o_done  (w_re_done),
        .o_top   (w_re_top)
    );

    blr_lane u_lane_im (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_u     (w_im_u),
        .i_wt    (r_rd_wt),
        .i_wx    (r_rd_wx),
        .o_done  (w_im_done),
        .o_top   (w_im_top)
    );

    // Echo of the queried point, delayed to match the lanes.
    logic [2*IDX_W-1:0] r_echo [3];

    always_ff @(posedge i_clk) begin
        r_echo[0] <= {r_rd_pt, r_rd_px};
        r_echo[1] <= r_echo[0];
        r_echo[2] <= r_echo[1];
    end

    blr_merge #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_merge (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_done    (w_re_done),
        .i_re_top  (w_re_top),
        .i_im_top  (w_im_top),
        .i_point_t (r_echo[2][2*IDX_W-1:IDX_W]),
        .i_point_x (r_echo[2][IDX_W-1:0]),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

    // Both lanes finish a query in the same cycle.
    a_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_re_done == w_im_done)
        else $error("lane completion mismatch");

    // A taken word starts its mapping at step zero.
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_d_valid && r_d_cnt == 2'd0))
        else $error("mapping stage did not start");

    // A finished mapping waits while the fetch stage is still busy.
    a_map_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_valid && r_d_cnt == 2'd3 && !w_r_free) |=> (r_d_valid && r_d_cnt == 2'd3))
        else $error("mapping result lost");

    // The memory port never writes and reads for a query in one cycle.
    a_port_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_wr_en && w_rd_en))
        else $error("memory port conflict");

    // A result strobe is never directly followed by another.
    a_result_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("results too close");

endmodule

`default_nettype wire

[src/blr_axis_map.sv]
// ============================================================================
// Axis mapping unit
// Maps a new-lattice index onto the stored lattice: floor(idx*(old-1)*2^16
// / (new-1)), seven restoring division steps per cycle while i_step is high.
// ============================================================================
`default_nettype none

module blr_axis_map
    import blr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_load,
    input  wire logic              i_step,
    input  wire logic [IDX_W-1:0]  i_idx,
    input  wire logic [SIZE_W-1:0] i_nold,
    input  wire logic [SIZE_W-1:0] i_nnew,
    output logic      [IDX_W-1:0]  o_ip,
    output logic      [FRAC_W-1:0] o_frac
);

    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [IDX_W-1:0] r_rem, n_rem;
    logic [QUO_W-1:0] r_quo, n_quo;
    logic [IDX_W-1:0] r_den;
    logic [IDX_W-1:0] w_den;
    logic [IDX_W-1:0] w_idx_sat;
    logic [NUM_W-1:0] w_num;
    logic [IDX_W:0]   v_try;

    // Saturate the index to the last new point and form the numerator.
    assign w_den     = IDX_W'(i_nnew - SIZE_W'(1));
    assign w_idx_sat = (i_idx > w_den) ? w_den : i_idx;
    assign w_num     = w_idx_sat * IDX_W'(i_nold - SIZE_W'(1));

    // Restoring division steps; the remainder always stays below the divisor.
    // The quotient never exceeds QUO_W bits, so its upper bits drop safely.
    always_comb begin
        n_rem = r_rem;
        n_dvd = r_dvd;
        n_quo = r_quo;
        v_try = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            v_try = {n_rem, n_dvd[DVD_W-1]};
            n_dvd = {n_dvd[DVD_W-2:0], 1'b0};
            if (v_try >= {1'b0, r_den}) begin
                n_rem = IDX_W'(v_try - {1'b0, r_den});
                n_quo = {n_quo[QUO_W-2:0], 1'b1};
            end else begin
                n_rem = v_try[IDX_W-1:0];
                n_quo = {n_quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    // Division state.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_dvd <= {w_num, {FRAC_W{1'b0}}};
            r_rem <= '0;
            r_quo <= '0;
            r_den <= w_den;
        end else if (i_step) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    // The last group of steps is taken straight into the next stage.
    assign o_ip   = n_quo[QUO_W-1:FRAC_W];
    assign o_frac = n_quo[FRAC_W-1:0];

endmodule

`default_nettype wire

[src/blr_lane.sv]
// ============================================================================
// Blend lane
// Weights one component of each neighbour and sums the four products,
// starting from the rounding half.
// ============================================================================
`default_nettype none

module blr_lane
    import blr_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_lane_ctl         i_ctl,
    input  wire logic [DATA_W-1:0] i_u,
    input  wire logic [WGT_W-1:0]  i_wt,
    input  wire logic [WGT_W-1:0]  i_wx,
    output logic                   o_done,
    output logic      [DATA_W-1:0] o_top
);

    localparam int P1_W  = DATA_W + WGT_W;
    localparam int ACC_W = 2 * DATA_W;
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (DATA_W - 1);

    t_lane_ctl                r_ctl1, r_ctl2;
    logic [P1_W-1:0]          r_p1;
    logic [WGT_W-1:0]         r_wx1;
    logic [ACC_W-1:0]         r_p2;
    logic [P1_W+WGT_W-1:0]    w_prod2;
    logic [ACC_W-1:0]         r_acc, n_acc;
    logic                     r_done;

    // Control pipeline alongside the two multiply stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
            r_done <= 1'b0;
        end else begin
            r_ctl1 <= i_ctl;
            r_ctl2 <= r_ctl1;
            r_done <= r_ctl2.vld && r_ctl2.last;
        end
    end

    // Offset sample times the time weight, then times the space weight.
    // The full product stays below 2^64 because the weights sum to 2^32.
    assign w_prod2 = r_p1 * r_wx1;

    always_ff @(posedge i_clk) begin
        r_p1  <= i_u * i_wt;
        r_wx1 <= i_wx;
        r_p2  <= w_prod2[ACC_W-1:0];
    end

    // Accumulate the four weighted neighbours.
    assign n_acc = (r_ctl2.first ? ROUND_HALF : r_acc) + r_p2;

    always_ff @(posedge i_clk) begin
        if (r_ctl2.vld) begin
            r_acc <= n_acc;
        end
    end

    assign o_done = r_done;
    assign o_top  = r_acc[ACC_W-1:DATA_W];

endmodule

`default_nettype wire

[src/blr_merge.sv]
// ============================================================================
// Result merge stage
// Removes the sample offset from both lane sums, saturates them and
// registers the result word with the echoed point.
// ============================================================================
`default_nettype none

module blr_merge
    import blr_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 32
)
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_done,
    input  wire logic [DATA_W-1:0] i_re_top,
    input  wire logic [DATA_W-1:0] i_im_top,
    input  wire logic [IDX_W-1:0]  i_point_t,
    input  wire logic [IDX_W-1:0]  i_point_x,
    output logic                   o_strobe,
    output t_out_item              o_result
);

    localparam logic signed [DATA_W-1:0] SAT_HI = DATA_W'((64'd1 << (SAMPLE_WIDTH - 1)) - 64'd1);
    localparam logic signed [DATA_W-1:0] SAT_LO = -SAT_HI - DATA_W'(1);

    logic      r_strobe;
    t_out_item r_result;

    // Undo the offset of 2^31 and clip to the sample range.
    function automatic logic signed [DATA_W-1:0] f_finish(input logic [DATA_W-1:0] top);
        logic signed [DATA_W-1:0] v;
        v = {~top[DATA_W-1], top[DATA_W-2:0]};
        if (v > SAT_HI) begin
            v = SAT_HI;
        end else if (v < SAT_LO) begin
            v = SAT_LO;
        end
        return v;
    endfunction

    // Output strobe.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_done;
        end
    end

    // Output word.
    always_ff @(posedge i_clk) begin
        if (i_done) begin
            r_result.re_out  <= f_finish(i_re_top);
            r_result.im_out  <= f_finish(i_im_top);
            r_result.point_t <= i_point_t;
            r_result.point_x <= i_point_x;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

[bench/tb_bilinear_lattice_resampler_top.sv]
// ============================================================================
// Testbench for the bilinear lattice resampler
// Loads stored lattices of several sizes, queries points of target lattices
// under both space boundary modes, and checks every result word against a
// bit-accurate interpolation predictor kept alongside the block or a typed
// value. A short stimulus table covers corners, edges and register clamping
// first; random phases with fresh layouts and random sender idling follow.
// ============================================================================

module tb_bilinear_lattice_resampler_top;
    import blr_pkg::*;

    localparam int SETTLE_CYCLES = 16;      // result latency plus slack
    localparam int CYCLE_LIMIT   = 40000;
    localparam int PHASES        = 9;
    localparam int MIX_WORDS     = 16;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_QUERY,
        ROW_REG
    } t_row_kind;

    // One line of the directed stimulus. For loads a/b are the stored
    // indexes, for queries the target indexes, for registers index/value.
    typedef struct packed {
        t_row_kind   kind;
        bit [6:0]    a;
        bit [6:0]    b;
        bit [31:0]   re;
        bit [31:0]   im;
        bit          known;
    } t_dir_row;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  start       = 1'b0;
    logic                  busy;
    t_in_item              drv_word    = '0;
    logic                  o_strobe;
    t_out_item             o_result;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = CFG_OLD_TIME;
    logic [SIZE_W-1:0]     i_cfg_wdata = '0;

    // Predictor state: stored lattice, which entries hold data, register copies.
    bit [63:0]   lat_mem [0:4095];
    bit          lat_written [0:4095];
    bit [6:0]    old_time_reg  = 7'd2;
    bit [6:0]    old_space_reg = 7'd2;
    bit [6:0]    new_time_reg  = 7'd2;
    bit [6:0]    new_space_reg = 7'd2;
    bit          bnd_reg       = BND_PERIODIC;

    t_out_item   pending_points [$];
    t_out_item   head_point;
    t_dir_row    dir_rows [$];
    int          idle_pct       = 30;
    int          err_count      = 0;
    int          points_checked = 0;
    int          loads_sent     = 0;
    int          layouts_used   = 0;
    int          cycle_cnt      = 0;

    bilinear_lattice_resampler_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (drv_word),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Size registers act as if clamped to 2..64.
    function automatic int unsigned clamp_points(bit [6:0] v);
        if (v < 7'd2) begin
            return 2;
        end else if (v > 7'd64) begin
            return 64;
        end
        return 32'(v);
    endfunction

    // Position on the stored axis: integer part over a 16-bit fraction.
    function automatic bit [21:0] map_axis(int unsigned idx, int unsigned nold,
                                           int unsigned nnew);
        int unsigned den;
        int unsigned num;
        int unsigned ip;
        int unsigned fr;
        den = nnew - 1;
        if (idx > den) begin
            idx = den;
        end
        num = idx * (nold - 1);
        ip  = num / den;
        fr  = ((num % den) << 16) / den;
        return {ip[5:0], fr[15:0]};
    endfunction

    // Weighted sum with offset-binary samples so the sum stays unsigned.
    // The weights always add up to one, so the result never leaves 32 bits.
    function automatic bit [31:0] blend_part(bit [3:0][31:0] s, bit [3:0][63:0] wt);
        bit [63:0] acc;
        int        k;
        acc = 64'h8000_0000;
        for (k = 0; k < 4; k++) begin
            acc += {32'd0, s[k] ^ 32'h8000_0000} * wt[k];
        end
        return acc[63:32] ^ 32'h8000_0000;
    endfunction

    // Interpolated answer for one query word under the current registers.
    function automatic t_out_item predict_point(t_in_item w);
        int unsigned     ot, ox, nt, nx, ti, tf, xi, xf, xn, tn;
        bit              has_t, has_x;
        bit [21:0]       pos;
        bit [63:0]       wt_t0, wt_t1, wt_x0, wt_x1;
        bit [3:0][63:0]  wt;
        bit [3:0][11:0]  addr;
        bit [3:0][31:0]  re_s, im_s;
        t_out_item       r;
        int              k;
        ot  = clamp_points(old_time_reg);
        ox  = clamp_points(old_space_reg);
        nt  = clamp_points(new_time_reg);
        nx  = clamp_points(new_space_reg);
        pos = map_axis(32'(w.new_t), ot, nt);
        ti  = 32'(pos[21:16]);
        tf  = 32'(pos[15:0]);
        pos = map_axis(32'(w.new_x), ox, nx);
        xi  = 32'(pos[21:16]);
        xf  = 32'(pos[15:0]);

        // Neighbours: none past the last time row; space wraps or stops.
        has_t = (ti < ot - 1);
        if (xi < ox - 1) begin
            has_x = 1'b1;
            xn    = xi + 1;
        end else if (bnd_reg == BND_PERIODIC) begin
            has_x = 1'b1;
            xn    = 0;
        end else begin
            has_x = 1'b0;
            xn    = xi;
        end
        tn = has_t ? ti + 1 : ti;
        addr[0] = {xi[5:0], ti[5:0]};
        addr[1] = {xn[5:0], ti[5:0]};
        addr[2] = {xi[5:0], tn[5:0]};
        addr[3] = {xn[5:0], tn[5:0]};

        wt_t1 = 64'(tf);
        wt_t0 = 64'(65536 - tf);
        wt_x1 = 64'(xf);
        wt_x0 = 64'(65536 - xf);
        wt    = '0;
        if (has_t && has_x) begin
            wt[0] = wt_t0 * wt_x0;
            wt[1] = wt_t0 * wt_x1;
            wt[2] = wt_t1 * wt_x0;
            wt[3] = wt_t1 * wt_x1;
        end else if (has_t) begin
            wt[0] = wt_t0 << 16;
            wt[2] = wt_t1 << 16;
        end else if (has_x) begin
            wt[0] = wt_x0 << 16;
            wt[1] = wt_x1 << 16;
        end else begin
            wt[0] = 64'h1_0000_0000;
        end

        for (k = 0; k < 4; k++) begin
            re_s[k] = lat_mem[addr[k]][31:0];
            im_s[k] = lat_mem[addr[k]][63:32];
        end
        r.re_out  = blend_part(re_s, wt);
        r.im_out  = blend_part(im_s, wt);
        r.point_t = w.new_t;
        r.point_x = w.new_x;
        return r;
    endfunction

    // Sample values lean toward the extremes now and then.
    function automatic bit [31:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item make_word(logic op, bit [5:0] ot, bit [5:0] ox,
                                           bit [31:0] re, bit [31:0] im,
                                           bit [5:0] nt, bit [5:0] nx);
        t_in_item w;
        w.op    = op;
        w.old_t = ot;
        w.old_x = ox;
        w.re_in = re;
        w.im_in = im;
        w.new_t = nt;
        w.new_x = nx;
        return w;
    endfunction

    // Present one word, wait for it to be taken, then book its effect.
    // Typed expectations replace the predictor for hand-checked rows.
    task automatic feed(input t_in_item w, input bit typed, input t_out_item typed_pt);
        start    <= 1'b1;
        drv_word <= w;
        do begin
            @(posedge i_clk);
        end while (busy !== 1'b0);
        if (w.op == OP_LOAD) begin
            lat_mem[{w.old_x, w.old_t}]     = {w.im_in, w.re_in};
            lat_written[{w.old_x, w.old_t}] = 1'b1;
            loads_sent++;
        end else if (typed) begin
            pending_points.push_back(typed_pt);
        end else begin
            pending_points.push_back(predict_point(w));
        end
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    endtask

    // Hold the sender until every result is back and the pipe has emptied.
    task automatic drain_results();
        start <= 1'b0;
        while (pending_points.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drive one register write; the caller lowers the enable afterwards.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input bit [6:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        case (idx)
            CFG_OLD_TIME:  old_time_reg  = val;
            CFG_OLD_SPACE: old_space_reg = val;
            CFG_NEW_TIME:  new_time_reg  = val;
            CFG_NEW_SPACE: new_space_reg = val;
            CFG_BOUNDARY:  bnd_reg       = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic set_layout(input bit [6:0] ot, input bit [6:0] ox, input bit [6:0] nt,
                              input bit [6:0] nx, input bit bnd);
        bit [6:0] bval;
        bval    = 7'($urandom_range(0, 127));
        bval[0] = bnd;
        drain_results();
        cfg_write(CFG_OLD_TIME, ot);
        cfg_write(CFG_OLD_SPACE, ox);
        cfg_write(CFG_NEW_TIME, nt);
        cfg_write(CFG_NEW_SPACE, nx);
        cfg_write(CFG_BOUNDARY, bval);
        i_cfg_we <= 1'b0;
        layouts_used++;
    endtask

    function automatic t_dir_row mk_row(t_row_kind kind, bit [6:0] a, bit [6:0] b,
                                        bit [31:0] re, bit [31:0] im, bit known);
        t_dir_row r;
        r.kind  = kind;
        r.a     = a;
        r.b     = b;
        r.re    = re;
        r.im    = im;
        r.known = known;
        return r;
    endfunction

    task automatic check_field(input string name, input bit [31:0] exp_v,
                               input bit [31:0] act_v);
        if (exp_v !== act_v) begin
            err_count++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
        end
    endtask

    // Each strobed result word is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_strobe !== 1'b0) begin
            if (pending_points.size() == 0) begin
                err_count++;
                $display("%0t: result word with none expected, expected nothing, got %h",
                         $time, o_result);
            end else begin
                head_point = pending_points.pop_front();
                check_field("re_out", head_point.re_out, o_result.re_out);
                check_field("im_out", head_point.im_out, o_result.im_out);
                check_field("point_t", {26'd0, head_point.point_t}, {26'd0, o_result.point_t});
                check_field("point_x", {26'd0, head_point.point_x}, {26'd0, o_result.point_x});
                points_checked++;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("FAIL bilinear_lattice_resampler_top");
            $finish;
        end
    end

    initial begin
        t_dir_row    row;
        t_out_item   typed_pt;
        int unsigned ot_c, ox_c, nt_c, nx_c;
        int          p, n, t, x;
        bit [6:0]    ot_v, ox_v, nt_v, nx_v;
        bit [5:0]    qt, qx;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part on the reset layout: 2x2 onto 2x2, periodic space.
        dir_rows.push_back(mk_row(ROW_LOAD, 7'd0, 7'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0));
        dir_rows.push_back(mk_row(ROW_LOAD, 7'd1, 7'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0));
        dir_rows.push_back(mk_row(ROW_LOAD, 7'd0, 7'd1, 32'h0001_0000, 32'hFFFF_0000, 1'b0));
        dir_rows.push_back(mk_row(ROW_LOAD, 7'd1, 7'd1, 32'h1234_5678, 32'hEDCB_A988, 1'b0));
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd0, 7'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1));
        // Last time row: no time neighbour.
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd1, 7'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1));
        // Last column wraps to column 0 with a zero fraction.
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd0, 7'd1, 32'h0001_0000, 32'hFFFF_0000, 1'b1));
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd1, 7'd1, 32'h1234_5678, 32'hEDCB_A988, 1'b1));
        // Indexes past the target lattice saturate; the echo stays raw.
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd63, 7'd63, 32'h1234_5678, 32'hEDCB_A988,
                                  1'b1));
        dir_rows.push_back(mk_row(ROW_REG, 7'(CFG_BOUNDARY), {6'd0, BND_OPEN}, 32'h0, 32'h0,
                                  1'b0));
        // Open edge and last row together: plain copy.
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd1, 7'd1, 32'h1234_5678, 32'hEDCB_A988, 1'b1));
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd0, 7'd1, 32'h0001_0000, 32'hFFFF_0000, 1'b1));
        // Target 3x3 puts points halfway between stored samples.
        dir_rows.push_back(mk_row(ROW_REG, 7'(CFG_NEW_TIME), 7'd3, 32'h0, 32'h0, 1'b0));
        dir_rows.push_back(mk_row(ROW_REG, 7'(CFG_NEW_SPACE), 7'd3, 32'h0, 32'h0, 1'b0));
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd1, 7'd1, 32'h0, 32'h0, 1'b0));
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd2, 7'd1, 32'h0, 32'h0, 1'b0));
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd1, 7'd2, 32'h0, 32'h0, 1'b0));
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd2, 7'd2, 32'h1234_5678, 32'hEDCB_A988, 1'b1));
        dir_rows.push_back(mk_row(ROW_REG, 7'(CFG_BOUNDARY), {6'd0, BND_PERIODIC}, 32'h0,
                                  32'h0, 1'b0));
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd1, 7'd2, 32'h0, 32'h0, 1'b0));
        dir_rows.push_back(mk_row(ROW_LOAD, 7'd0, 7'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0));
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd0, 7'd0, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1));
        // Out-of-range size registers.
        dir_rows.push_back(mk_row(ROW_REG, 7'(CFG_OLD_TIME), 7'd0, 32'h0, 32'h0, 1'b0));
        dir_rows.push_back(mk_row(ROW_REG, 7'(CFG_NEW_TIME), 7'd127, 32'h0, 32'h0, 1'b0));
        dir_rows.push_back(mk_row(ROW_QUERY, 7'd63, 7'd0, 32'h0, 32'h0, 1'b0));

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            typed_pt.re_out  = row.re;
            typed_pt.im_out  = row.im;
            typed_pt.point_t = row.a[5:0];
            typed_pt.point_x = row.b[5:0];
            case (row.kind)
                ROW_REG: begin
                    drain_results();
                    cfg_write(row.a[CFG_IDX_W-1:0], row.b);
                    i_cfg_we <= 1'b0;
                end
                ROW_LOAD: begin
                    feed(make_word(OP_LOAD, row.a[5:0], row.b[5:0], row.re, row.im,
                                   6'($urandom), 6'($urandom)), 1'b0, typed_pt);
                end
                default: begin
                    feed(make_word(OP_QUERY, 6'($urandom), 6'($urandom), $urandom, $urandom,
                                   row.a[5:0], row.b[5:0]), row.known, typed_pt);
                end
            endcase
        end

        // Random phases: new layout, fill the stored lattice, then mix.
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    ot_v = 7'd64; ox_v = 7'd2; nt_v = 7'd64; nx_v = 7'd2;
                end
                1: begin
                    ot_v = 7'd2; ox_v = 7'd64; nt_v = 7'd5; nx_v = 7'd64;
                end
                2: begin
                    ot_v = 7'd127; ox_v = 7'd0; nt_v = 7'd0; nx_v = 7'd127;
                end
                3: begin
                    ot_v = 7'd1; ox_v = 7'd1; nt_v = 7'd100; nx_v = 7'd3;
                end
                default: begin
                    ot_v = 7'($urandom_range(2, 8));
                    ox_v = 7'($urandom_range(2, 8));
                    nt_v = 7'($urandom_range(0, 1) ? $urandom_range(2, 16)
                                                   : $urandom_range(0, 127));
                    nx_v = 7'($urandom_range(0, 1) ? $urandom_range(2, 16)
                                                   : $urandom_range(0, 127));
                end
            endcase
            idle_pct = (p == PHASES - 1) ? 0 : 20 * $urandom_range(0, 3);
            set_layout(ot_v, ox_v, nt_v, nx_v, p[0]);
            ot_c = clamp_points(old_time_reg);
            ox_c = clamp_points(old_space_reg);
            nt_c = clamp_points(new_time_reg);
            nx_c = clamp_points(new_space_reg);

            // Every stored entry a query can reach holds data before the mix.
            for (x = 0; x < ox_c; x++) begin
                for (t = 0; t < ot_c; t++) begin
                    if (!lat_written[{6'(x), 6'(t)}]) begin
                        feed(make_word(OP_LOAD, 6'(t), 6'(x), rand_sample(), rand_sample(),
                                       6'($urandom), 6'($urandom)), 1'b0, typed_pt);
                    end
                end
            end

            for (n = 0; n < MIX_WORDS; n++) begin
                if ($urandom_range(0, 9) < 7) begin
                    qt = 6'($urandom_range(0, 1) ? $urandom_range(0, nt_c - 1)
                                                 : $urandom_range(0, 63));
                    qx = 6'($urandom_range(0, 1) ? $urandom_range(0, nx_c - 1)
                                                 : $urandom_range(0, 63));
                    feed(make_word(OP_QUERY, 6'($urandom), 6'($urandom), $urandom, $urandom,
                                   qt, qx), 1'b0, typed_pt);
                end else if ($urandom_range(0, 4) != 0) begin
                    feed(make_word(OP_LOAD, 6'($urandom_range(0, ot_c - 1)),
                                   6'($urandom_range(0, ox_c - 1)), rand_sample(),
                                   rand_sample(), 6'($urandom), 6'($urandom)),
                         1'b0, typed_pt);
                end else begin
                    feed(make_word(OP_LOAD, 6'($urandom), 6'($urandom), rand_sample(),
                                   rand_sample(), 6'($urandom), 6'($urandom)),
                         1'b0, typed_pt);
                end
                if ($urandom_range(0, 59) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        $display("Resampled %0d points after %0d sample loads over %0d random layouts,",
                 points_checked, loads_sent, layouts_used);
        $display("both boundary modes, clamped sizes, edge rows and saturated indexes.");
        if (err_count == 0) begin
            $display("PASS bilinear_lattice_resampler_top");
        end else begin
            $display("FAIL bilinear_lattice_resampler_top");
        end
        $finish;
    end

endmodule
